// ----- hdl/hsv_to_rgb_converter_macros.svh -----
// ----------------------------------------------------------------------------
// HSV to RGB converter assertion macros
// Shared property wrappers used by the pipeline modules.
// ----------------------------------------------------------------------------
`ifndef HSV_TO_RGB_CONVERTER_MACROS_SVH
`define HSV_TO_RGB_CONVERTER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define HSV_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("hsv_to_rgb_converter: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define HSV_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("hsv_to_rgb_converter: next-cycle check failed");

`endif

// ----- hdl/hsv_pkg.sv -----
// ----------------------------------------------------------------------------
// HSV to RGB converter package
// Shared constants, beat types and arithmetic helpers.
// ----------------------------------------------------------------------------
package hsv_pkg;

   localparam int unsigned HUE_W     = 16;
   localparam int unsigned CHAN_W    = 8;
   localparam int unsigned REM_W     = 9;
   localparam int unsigned QUO_W     = 8;
   localparam int unsigned OFFSET_W  = 6;
   localparam int unsigned SECTOR_W  = 3;

   localparam int unsigned HUE_PERIOD  = 360;
   localparam int unsigned SECTOR_SPAN = 60;
   localparam int unsigned FULL_SCALE  = 255;
   localparam int unsigned SCALE_SHIFT = 8;

   // floor(hue / 360) == (hue * RECIP_MULT) >> RECIP_SHIFT for every 16-bit hue.
   localparam int unsigned RECIP_SHIFT = 24;
   localparam int unsigned RECIP_MULT  = ((1 << RECIP_SHIFT) + HUE_PERIOD - 1) / HUE_PERIOD;

   // 255 / 60 reduces to 17 / 4, so the fraction scale is exact.
   localparam int unsigned FRAC_MULT  = 17;
   localparam int unsigned FRAC_SHIFT = 2;

   typedef logic [SECTOR_W-1:0] sector_type;

   localparam sector_type SECTOR_RED_YELLOW    = 3'd0;
   localparam sector_type SECTOR_YELLOW_GREEN  = 3'd1;
   localparam sector_type SECTOR_GREEN_CYAN    = 3'd2;
   localparam sector_type SECTOR_CYAN_BLUE     = 3'd3;
   localparam sector_type SECTOR_BLUE_MAGENTA  = 3'd4;
   localparam sector_type SECTOR_MAGENTA_RED   = 3'd5;

   typedef struct packed {
      logic [HUE_W-1:0]  hue;
      logic [CHAN_W-1:0] saturation;
      logic [CHAN_W-1:0] brightness;
   } hsv_beat_type;

   typedef struct packed {
      sector_type        sector;
      logic [CHAN_W-1:0] frac;
      logic [CHAN_W-1:0] saturation;
      logic [CHAN_W-1:0] brightness;
   } hsv_split_type;

   typedef struct packed {
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
   } rgb_beat_type;

   // 8-bit scaled product (a * b) >> 8.
   function automatic logic [CHAN_W-1:0] scaled_product(input logic [CHAN_W-1:0] a,
                                                        input logic [CHAN_W-1:0] b);
      logic [2*CHAN_W-1:0] prod;
      prod = a * b;
      return prod[2*CHAN_W-1:SCALE_SHIFT];
   endfunction

   // Offset within a sector (0..59) scaled to 0..250.
   function automatic logic [CHAN_W-1:0] frac_of(input logic [OFFSET_W-1:0] offset);
      logic [OFFSET_W+FRAC_SHIFT+3-1:0] prod;
      prod = offset * (OFFSET_W+FRAC_SHIFT+3)'(FRAC_MULT);
      return CHAN_W'(prod >> FRAC_SHIFT);
   endfunction

endpackage

// ----- hdl/hsv_skid.sv -----
// ----------------------------------------------------------------------------
// HSV input skid buffer
// Registers the upstream ready so the sink's stall path ends here.
// ----------------------------------------------------------------------------
module hsv_skid (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  hsv_pkg::hsv_beat_type in_beat,
   output logic                 out_valid,
   input  logic                 out_ready,
   output hsv_pkg::hsv_beat_type out_beat
);
   import hsv_pkg::*;

   logic         skid_valid_ff;
   logic         skid_valid_in;
   hsv_beat_type skid_beat_ff;
   logic         load;

   // A beat is parked only when it arrives while the pipeline is stalled.
   assign load = in_valid && !skid_valid_ff && !out_ready;

   always_comb begin
      skid_valid_in = skid_valid_ff;
      if (load) begin
         skid_valid_in = 1'b1;
      end else if (out_ready) begin
         skid_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         skid_valid_ff <= 1'b0;
      end else begin
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         skid_beat_ff <= in_beat;
      end
   end

   assign in_ready  = !skid_valid_ff;
   assign out_valid = skid_valid_ff || in_valid;
   assign out_beat  = skid_valid_ff ? skid_beat_ff : in_beat;

endmodule

// ----- hdl/hsv_hue_split.sv -----
// ----------------------------------------------------------------------------
// HSV hue split
// Three stages: reciprocal quotient, remainder mod 360, sector and fraction.
// ----------------------------------------------------------------------------
`include "hsv_to_rgb_converter_macros.svh"

module hsv_hue_split (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  hsv_pkg::hsv_beat_type  in_beat,
   output logic                  out_valid,
   input  logic                  out_ready,
   output hsv_pkg::hsv_split_type out_beat
);
   import hsv_pkg::*;

   localparam int unsigned PROD_W = HUE_W + RECIP_SHIFT - HUE_W + HUE_W;

   // Stage 1: quotient by reciprocal multiply.
   logic              s1_valid_ff, s1_valid_in, s1_ready;
   logic [QUO_W-1:0]  s1_quo_ff, s1_quo_in;
   hsv_beat_type      s1_beat_ff;
   logic [PROD_W-1:0] recip_prod;

   // Stage 2: remainder.
   logic              s2_valid_ff, s2_valid_in, s2_ready;
   logic [REM_W-1:0]  s2_rem_ff, s2_rem_in;
   logic [CHAN_W-1:0] s2_sat_ff, s2_bright_ff;
   logic [HUE_W-1:0]  quo_times_period;

   // Stage 3: sector and fraction.
   logic              s3_valid_ff, s3_valid_in, s3_ready;
   hsv_split_type     s3_beat_ff, s3_beat_in;
   logic [REM_W-1:0]  sector_base;
   logic [REM_W-1:0]  offset_wide;

   assign s3_ready = !s3_valid_ff || out_ready;
   assign s2_ready = !s2_valid_ff || s3_ready;
   assign s1_ready = !s1_valid_ff || s2_ready;
   assign in_ready = s1_ready;

   always_comb begin
      recip_prod  = in_beat.hue * PROD_W'(RECIP_MULT);
      s1_quo_in   = QUO_W'(recip_prod >> RECIP_SHIFT);
      s1_valid_in = s1_ready ? in_valid : s1_valid_ff;
   end

   always_comb begin
      quo_times_period = HUE_W'(s1_quo_ff * HUE_W'(HUE_PERIOD));
      s2_rem_in        = REM_W'(s1_beat_ff.hue - quo_times_period);
      s2_valid_in      = s2_ready ? s1_valid_ff : s2_valid_ff;
   end

   always_comb begin
      if (s2_rem_ff >= REM_W'(5 * SECTOR_SPAN)) begin
         s3_beat_in.sector = SECTOR_MAGENTA_RED;
      end else if (s2_rem_ff >= REM_W'(4 * SECTOR_SPAN)) begin
         s3_beat_in.sector = SECTOR_BLUE_MAGENTA;
      end else if (s2_rem_ff >= REM_W'(3 * SECTOR_SPAN)) begin
         s3_beat_in.sector = SECTOR_CYAN_BLUE;
      end else if (s2_rem_ff >= REM_W'(2 * SECTOR_SPAN)) begin
         s3_beat_in.sector = SECTOR_GREEN_CYAN;
      end else if (s2_rem_ff >= REM_W'(SECTOR_SPAN)) begin
         s3_beat_in.sector = SECTOR_YELLOW_GREEN;
      end else begin
         s3_beat_in.sector = SECTOR_RED_YELLOW;
      end
      case (s3_beat_in.sector)
         SECTOR_RED_YELLOW:   sector_base = '0;
         SECTOR_YELLOW_GREEN: sector_base = REM_W'(SECTOR_SPAN);
         SECTOR_GREEN_CYAN:   sector_base = REM_W'(2 * SECTOR_SPAN);
         SECTOR_CYAN_BLUE:    sector_base = REM_W'(3 * SECTOR_SPAN);
         SECTOR_BLUE_MAGENTA: sector_base = REM_W'(4 * SECTOR_SPAN);
         default:             sector_base = REM_W'(5 * SECTOR_SPAN);
      endcase
      offset_wide           = s2_rem_ff - sector_base;
      s3_beat_in.frac       = frac_of(offset_wide[OFFSET_W-1:0]);
      s3_beat_in.saturation = s2_sat_ff;
      s3_beat_in.brightness = s2_bright_ff;
      s3_valid_in           = s3_ready ? s2_valid_ff : s3_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         s3_valid_ff <= s3_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_ready) begin
         s1_quo_ff  <= s1_quo_in;
         s1_beat_ff <= in_beat;
      end
      if (s2_ready) begin
         s2_rem_ff    <= s2_rem_in;
         s2_sat_ff    <= s1_beat_ff.saturation;
         s2_bright_ff <= s1_beat_ff.brightness;
      end
      if (s3_ready) begin
         s3_beat_ff <= s3_beat_in;
      end
   end

   assign out_valid = s3_valid_ff;
   assign out_beat  = s3_beat_ff;

   `HSV_ASSERT_IMPLY(a_rem_below_period, clock, reset, s2_valid_ff, s2_rem_ff < REM_W'(HUE_PERIOD))
   `HSV_ASSERT_IMPLY(a_frac_in_range, clock, reset, s3_valid_ff, (s3_beat_ff.frac <= CHAN_W'(250)) && (s3_beat_ff.sector <= SECTOR_MAGENTA_RED))
   `HSV_ASSERT_NEXT(a_stage3_holds, clock, reset, s3_valid_ff && !out_ready, s3_valid_ff && $stable(s3_beat_ff))

endmodule

// ----- hdl/hsv_scale.sv -----
// ----------------------------------------------------------------------------
// HSV scale and select
// Two multiply stages form p, q and t, then the sector routes them to RGB.
// ----------------------------------------------------------------------------
`include "hsv_to_rgb_converter_macros.svh"

module hsv_scale (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  hsv_pkg::hsv_split_type in_beat,
   output logic                  out_valid,
   input  logic                  out_ready,
   output hsv_pkg::rgb_beat_type  out_beat
);
   import hsv_pkg::*;

   // Stage 4: p and the two saturation products.
   logic              s4_valid_ff, s4_valid_in, s4_ready;
   sector_type        s4_sector_ff;
   logic [CHAN_W-1:0] s4_bright_ff;
   logic [CHAN_W-1:0] s4_p_ff, s4_p_in;
   logic [CHAN_W-1:0] s4_ms_ff, s4_ms_in;
   logic [CHAN_W-1:0] s4_mt_ff, s4_mt_in;

   // Stage 5: q, t and the routed output.
   logic              s5_valid_ff, s5_valid_in, s5_ready;
   rgb_beat_type      s5_beat_ff, s5_beat_in;
   logic [CHAN_W-1:0] s5_bright_ff;
   logic [CHAN_W-1:0] s5_p_ff;
   logic [CHAN_W-1:0] term_q, term_t;

   assign s5_ready = !s5_valid_ff || out_ready;
   assign s4_ready = !s4_valid_ff || s5_ready;
   assign in_ready = s4_ready;

   always_comb begin
      s4_p_in     = scaled_product(in_beat.brightness, CHAN_W'(FULL_SCALE) - in_beat.saturation);
      s4_ms_in    = scaled_product(in_beat.saturation, in_beat.frac);
      s4_mt_in    = scaled_product(in_beat.saturation, CHAN_W'(FULL_SCALE) - in_beat.frac);
      s4_valid_in = s4_ready ? in_valid : s4_valid_ff;
   end

   always_comb begin
      term_q = scaled_product(s4_bright_ff, CHAN_W'(FULL_SCALE) - s4_ms_ff);
      term_t = scaled_product(s4_bright_ff, CHAN_W'(FULL_SCALE) - s4_mt_ff);
      case (s4_sector_ff)
         SECTOR_RED_YELLOW:   s5_beat_in = '{red: s4_bright_ff, green: term_t, blue: s4_p_ff};
         SECTOR_YELLOW_GREEN: s5_beat_in = '{red: term_q, green: s4_bright_ff, blue: s4_p_ff};
         SECTOR_GREEN_CYAN:   s5_beat_in = '{red: s4_p_ff, green: s4_bright_ff, blue: term_t};
         SECTOR_CYAN_BLUE:    s5_beat_in = '{red: s4_p_ff, green: term_q, blue: s4_bright_ff};
         SECTOR_BLUE_MAGENTA: s5_beat_in = '{red: term_t, green: s4_p_ff, blue: s4_bright_ff};
         default:             s5_beat_in = '{red: s4_bright_ff, green: s4_p_ff, blue: term_q};
      endcase
      s5_valid_in = s5_ready ? s4_valid_ff : s5_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
         s5_valid_ff <= 1'b0;
      end else begin
         s4_valid_ff <= s4_valid_in;
         s5_valid_ff <= s5_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s4_ready) begin
         s4_sector_ff <= in_beat.sector;
         s4_bright_ff <= in_beat.brightness;
         s4_p_ff      <= s4_p_in;
         s4_ms_ff     <= s4_ms_in;
         s4_mt_ff     <= s4_mt_in;
      end
      if (s5_ready) begin
         s5_beat_ff   <= s5_beat_in;
         s5_bright_ff <= s4_bright_ff;
         s5_p_ff      <= s4_p_ff;
      end
   end

   assign out_valid = s5_valid_ff;
   assign out_beat  = s5_beat_ff;

   // The value itself always lands on one channel, and p is never above any channel.
   `HSV_ASSERT_IMPLY(a_value_routed, clock, reset, s5_valid_ff, (s5_beat_ff.red == s5_bright_ff) || (s5_beat_ff.green == s5_bright_ff) || (s5_beat_ff.blue == s5_bright_ff))
   `HSV_ASSERT_IMPLY(a_p_is_floor, clock, reset, s5_valid_ff, (s5_p_ff <= s5_beat_ff.red) && (s5_p_ff <= s5_beat_ff.green) && (s5_p_ff <= s5_beat_ff.blue))

endmodule

// ----- hdl/hsv_to_rgb_converter.sv -----
// ----------------------------------------------------------------------------
// HSV to RGB converter: 8-bit integer conversion, five-stage pipeline.
// Throughput: one beat per cycle while rsp_tready is high; the multiplies
// of stages 1 to 5 set depth.
// Reset: synchronous, active high; clears all valid bits and the skid buffer.
// ----------------------------------------------------------------------------
module hsv_to_rgb_converter (
   input  logic        clock,
   input  logic        reset,
   // Input beat, from bit 0 up: hue[15:0], saturation[23:16], brightness[31:24].
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,
   // Result beat, from bit 0 up: red[7:0], green[15:8], blue[23:16].
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata
);
   import hsv_pkg::*;

   // The skid buffer keeps req_tready a register output, so the stall path
   // from rsp_tready through the per-stage ready chain stops inside the block.
   // Each stage advances when it is empty or its successor advances, so
   // bubbles collapse and a stalled stage keeps its beat.

   hsv_beat_type  req_beat;
   hsv_beat_type  skid_beat;
   hsv_split_type split_beat;
   rgb_beat_type  rgb_beat;
   logic          skid_valid, skid_ready;
   logic          split_valid, split_ready;

   always_comb begin
      req_beat.hue        = req_tdata[15:0];
      req_beat.saturation = req_tdata[23:16];
      req_beat.brightness = req_tdata[31:24];
   end

   hsv_skid u_skid (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_beat   (req_beat),
      .out_valid (skid_valid),
      .out_ready (skid_ready),
      .out_beat  (skid_beat)
   );

   // Stages 1 to 3: hue mod 360 by reciprocal multiply, then sector and fraction.
   hsv_hue_split u_hue_split (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (skid_valid),
      .in_ready  (skid_ready),
      .in_beat   (skid_beat),
      .out_valid (split_valid),
      .out_ready (split_ready),
      .out_beat  (split_beat)
   );

   // Stages 4 and 5: the scaled products p, q, t and the sector routing.
   hsv_scale u_scale (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (split_valid),
      .in_ready  (split_ready),
      .in_beat   (split_beat),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_beat  (rgb_beat)
   );

   assign rsp_tdata = {rgb_beat.blue, rgb_beat.green, rgb_beat.red};

endmodule

// ----- dv/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HSV to RGB converter testbench
// Sends hue, saturation and brightness beats into the converter and checks
// every red, green and blue beat against a predictor of the 8-bit integer
// conversion. A directed table comes first, then random beats under several
// sender and receiver idling mixes, with a long receiver hold-off.
// ----------------------------------------------------------------------------
module tb;
   import hsv_pkg::*;

   // The run stops here even if the converter hangs. This bound leaves a wide
   // margin over a correct run.
   localparam int unsigned CYCLE_LIMIT      = 200000;
   localparam int unsigned BEATS_PER_PHASE  = 220;
   localparam int unsigned FLOOD_BEATS      = 40;
   localparam int unsigned HOLD_OFF_CYCLES  = 60;
   // After the last owed color has come back, wait this long for a stray
   // result before calling the run finished.
   localparam int unsigned SETTLE_CYCLES    = 16;
   localparam int unsigned DIRECTED_ROWS    = 25;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   // From bit 0 up: hue[15:0], saturation[23:16], brightness[31:24].
   logic [31:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   // From bit 0 up: red[7:0], green[15:8], blue[23:16].
   logic [23:0] rsp_tdata;

   hsv_to_rgb_converter dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // 100 MHz clock.
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Colors still owed by the converter, oldest first.
   rgb_beat_type pending_rgb_q[$];
   int unsigned  failures = 0;
   int unsigned  cycle_count = 0;

   // Idling mix of the current phase, in percent of cycles.
   int unsigned  send_idle_pct = 0;
   int unsigned  stall_pct = 0;

   // Long hold-off of the result side, requested by the stimulus process and
   // counted down by the receiver process.
   bit           hold_off_request = 1'b0;
   int unsigned  hold_off_left = 0;

   // One row of the directed table. Where typed is set, the color is written
   // out by hand; otherwise the predictor supplies it.
   typedef struct {
      logic [HUE_W-1:0]  hue;
      logic [CHAN_W-1:0] saturation;
      logic [CHAN_W-1:0] brightness;
      bit                typed;
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
   } directed_row_type;

   // The table covers both ends of every field, the first and last degree of
   // each sector, hues of 360 and above that wrap back into range, and
   // alternating bit patterns on all three fields.
   directed_row_type directed_rows [DIRECTED_ROWS] = '{
      // Pure red at hue 0: p and t collapse to zero at full saturation.
      '{16'd0,     8'd255, 8'd255, 1'b1, 8'd255, 8'd0,   8'd0  },
      // No saturation: the value channel passes, the others lose one step.
      '{16'd0,     8'd0,   8'd255, 1'b1, 8'd255, 8'd254, 8'd254},
      // Zero brightness gives black for any hue.
      '{16'd0,     8'd255, 8'd0,   1'b1, 8'd0,   8'd0,   8'd0  },
      '{16'd200,   8'd0,   8'd0,   1'b1, 8'd0,   8'd0,   8'd0  },
      '{16'd65535, 8'd0,   8'd0,   1'b1, 8'd0,   8'd0,   8'd0  },
      '{16'd59,    8'd255, 8'd255, 1'b0, 8'd0,   8'd0,   8'd0  },
      '{16'd60,    8'd255, 8'd255, 1'b0, 8'd0,   8'd0,   8'd0  },
      '{16'd119,   8'd200, 8'd180, 1'b0, 8'd0,   8'd0,   8'd0  },
      // Pure green at the start of the green-cyan sector.
      '{16'd120,   8'd255, 8'd255, 1'b1, 8'd0,   8'd255, 8'd0  },
      '{16'd179,   8'd128, 8'd255, 1'b0, 8'd0,   8'd0,   8'd0  },
      '{16'd180,   8'd255, 8'd255, 1'b0, 8'd0,   8'd0,   8'd0  },
      '{16'd239,   8'd255, 8'd128, 1'b0, 8'd0,   8'd0,   8'd0  },
      // Pure blue at the start of the blue-magenta sector.
      '{16'd240,   8'd255, 8'd255, 1'b1, 8'd0,   8'd0,   8'd255},
      '{16'd299,   8'd64,  8'd200, 1'b0, 8'd0,   8'd0,   8'd0  },
      '{16'd300,   8'd255, 8'd255, 1'b0, 8'd0,   8'd0,   8'd0  },
      '{16'd359,   8'd255, 8'd255, 1'b0, 8'd0,   8'd0,   8'd0  },
      // Hues of one and of 182 whole turns land back on pure red.
      '{16'd360,   8'd255, 8'd255, 1'b1, 8'd255, 8'd0,   8'd0  },
      '{16'd65520, 8'd255, 8'd255, 1'b1, 8'd255, 8'd0,   8'd0  },
      '{16'd719,   8'd17,  8'd99,  1'b0, 8'd0,   8'd0,   8'd0  },
      '{16'd65535, 8'd255, 8'd255, 1'b0, 8'd0,   8'd0,   8'd0  },
      '{16'd30,    8'd1,   8'd1,   1'b0, 8'd0,   8'd0,   8'd0  },
      '{16'd90,    8'd254, 8'd254, 1'b0, 8'd0,   8'd0,   8'd0  },
      '{16'd32768, 8'd170, 8'd85,  1'b0, 8'd0,   8'd0,   8'd0  },
      '{16'd21845, 8'd85,  8'd170, 1'b0, 8'd0,   8'd0,   8'd0  },
      '{16'd43690, 8'd255, 8'd127, 1'b0, 8'd0,   8'd0,   8'd0  }
   };

   // (a * b) >> 8 on 8-bit operands, the scaling used for every term.
   function automatic logic [CHAN_W-1:0] mul_shift8(input logic [CHAN_W-1:0] a,
                                                    input logic [CHAN_W-1:0] b);
      logic [2*CHAN_W-1:0] full;
      full = a * b;
      return full[2*CHAN_W-1:CHAN_W];
   endfunction

   // Predicts the color for one input beat.
   function automatic rgb_beat_type predict_rgb(input hsv_beat_type beat);
      int unsigned       degrees;
      sector_type        sector;
      logic [CHAN_W-1:0] frac;
      logic [CHAN_W-1:0] v;
      logic [CHAN_W-1:0] s;
      logic [CHAN_W-1:0] p;
      logic [CHAN_W-1:0] q;
      logic [CHAN_W-1:0] t;
      rgb_beat_type      rgb;
      degrees = beat.hue % HUE_PERIOD;
      sector  = sector_type'(degrees / SECTOR_SPAN);
      frac    = CHAN_W'(((degrees % SECTOR_SPAN) * FULL_SCALE) / SECTOR_SPAN);
      v = beat.brightness;
      s = beat.saturation;
      p = mul_shift8(v, CHAN_W'(FULL_SCALE) - s);
      q = mul_shift8(v, CHAN_W'(FULL_SCALE) - mul_shift8(s, frac));
      t = mul_shift8(v, CHAN_W'(FULL_SCALE) - mul_shift8(s, CHAN_W'(FULL_SCALE) - frac));
      case (sector)
         SECTOR_RED_YELLOW:   rgb = '{v, t, p};
         SECTOR_YELLOW_GREEN: rgb = '{q, v, p};
         SECTOR_GREEN_CYAN:   rgb = '{p, v, t};
         SECTOR_CYAN_BLUE:    rgb = '{p, q, v};
         SECTOR_BLUE_MAGENTA: rgb = '{t, p, v};
         default:             rgb = '{v, p, q};
      endcase
      return rgb;
   endfunction

   // A channel value that lands on either end fairly often, random otherwise.
   function automatic logic [CHAN_W-1:0] random_channel();
      logic [CHAN_W-1:0] level;
      case ($urandom_range(7))
         0:       level = '0;
         1:       level = '1;
         default: level = CHAN_W'($urandom);
      endcase
      return level;
   endfunction

   // Random input beat. Hues are spread over the whole 16-bit range, over
   // the first turn, over the edges of sectors, and over a few turns.
   function automatic hsv_beat_type random_hsv();
      hsv_beat_type beat;
      case ($urandom_range(3))
         0: beat.hue = HUE_W'($urandom);
         1: beat.hue = HUE_W'($urandom_range(HUE_PERIOD - 1));
         2: beat.hue = HUE_W'(SECTOR_SPAN * $urandom_range(5)
                              + ($urandom_range(1) ? SECTOR_SPAN - 1 : 0)
                              + HUE_PERIOD * $urandom_range(181));
         default: beat.hue = HUE_W'($urandom_range(3 * HUE_PERIOD - 1));
      endcase
      beat.saturation = random_channel();
      beat.brightness = random_channel();
      return beat;
   endfunction

   // Offers one beat, idling first as often as the phase asks, and records
   // the color owed once the converter takes the beat. Valid stays high into
   // the next call unless that call chooses to idle.
   task automatic send_hsv(input hsv_beat_type beat, input bit typed,
                           input rgb_beat_type typed_rgb);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {beat.brightness, beat.saturation, beat.hue};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pending_rgb_q.push_back(typed ? typed_rgb : predict_rgb(beat));
   endtask

   // Drops valid and waits until every owed color has come back.
   task automatic drain_colors();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_rgb_q.size() != 0) @(posedge clock);
   endtask

   task automatic send_random_phase(input int unsigned idle, input int unsigned stall);
      send_idle_pct = idle;
      stall_pct     = stall;
      repeat (BEATS_PER_PHASE) send_hsv(random_hsv(), 1'b0, '0);
      drain_colors();
   endtask

   task automatic check_channel(input string name, input logic [CHAN_W-1:0] expected,
                                input logic [CHAN_W-1:0] actual);
      if (actual !== expected) begin
         $error("%s mismatch: expected %0d, got %0d", name, expected, actual);
         failures++;
      end
   endtask

   // Result side: ready changes on the falling edge. A pending hold-off
   // keeps it low for a long stretch; otherwise the phase's stall rate rules.
   always @(negedge clock) begin
      if (hold_off_request) begin
         hold_off_left    = HOLD_OFF_CYCLES;
         hold_off_request = 1'b0;
      end
      if (hold_off_left > 0) begin
         hold_off_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // Every accepted result beat is held against the oldest owed color.
   always @(posedge clock) begin
      rgb_beat_type expected;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_rgb_q.size() == 0) begin
            $error("unexpected result beat: tdata %06h", rsp_tdata);
            failures++;
         end else begin
            expected = pending_rgb_q.pop_front();
            check_channel("red",   expected.red,   rsp_tdata[7:0]);
            check_channel("green", expected.green, rsp_tdata[15:8]);
            check_channel("blue",  expected.blue,  rsp_tdata[23:16]);
         end
      end
   end

   // Watchdog: a hung handshake ends the run here.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   initial begin
      hsv_beat_type beat;
      rgb_beat_type typed_rgb;

      // Reset is held from time zero and released on a falling edge.
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed table with both sides always ready.
      foreach (directed_rows[i]) begin
         beat      = '{directed_rows[i].hue, directed_rows[i].saturation,
                       directed_rows[i].brightness};
         typed_rgb = '{directed_rows[i].red, directed_rows[i].green,
                       directed_rows[i].blue};
         send_hsv(beat, directed_rows[i].typed, typed_rgb);
      end
      // The sender waits here until every owed color has arrived.
      drain_colors();

      // Back-pressure: the result side holds off for a long stretch while
      // beats keep coming, so the pipeline and its skid buffer fill and the
      // input side has to stall.
      hold_off_request = 1'b1;
      repeat (FLOOD_BEATS) send_hsv(random_hsv(), 1'b0, '0);
      drain_colors();

      // Random beats under each idling mix, ending with a clean stretch.
      send_random_phase(0, 0);
      send_random_phase(53, 0);
      send_random_phase(0, 53);
      send_random_phase(19, 19);
      send_random_phase(0, 0);

      // Nothing is owed now; give a late stray beat time to show up.
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (failures == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
